// File: sv/iatr_pkg.sv
`default_nettype none

package iatr_pkg;

   // Fixed field widths
   localparam int MODE_W     = 3;
   localparam int DIM_FLD_W  = 13;
   localparam int SCL_FLD_W  = 4;
   localparam int PIX_W      = 24;
   localparam int IDX_W      = 30;
   localparam int ODIM_W     = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_ENLARGE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ROT_CW  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ROT_CCW = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MIRROR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HALF    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ROWS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_COLS = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 4'd3;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [DIM_FLD_W-1:0] src_rows;
      logic [DIM_FLD_W-1:0] src_cols;
      logic [SCL_FLD_W-1:0] scale;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MULT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;   // take pixel, advance counters
      logic scale;  // scaled operands and frame size
      logic mult;   // base index product
      logic step;   // result transfer done, next copy
   } ctrl_cmd_type;

   typedef struct packed {
      logic last;   // current result is the last of its pixel
   } ctrl_sts_type;

endpackage

`default_nettype wire

// File: sv/image_transform_address_remap_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  pixel_in
// rsp_      out        rsp_valid/rsp_stall  dest_index, pixel_out, run_last,
//                                           frame_last, out_rows, out_cols
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// One pixel at a time. After the input transfer, the scale state registers
// the scaled operands, the mult state forms the base index with one multiply,
// then results go out: scale*scale per pixel in enlarge, one otherwise.
// Output stalls hold the current result and the sequencer in place.
// Reset (synchronous) loads mode 0, 1x1 frame, scale 1, counters at zero.
// Any mapped register write restarts the frame; csr_ready is always high.

module image_transform_address_remap_top
   import iatr_pkg::*;
#(
   parameter int MAX_DIM   = 4096,
   parameter int MAX_SCALE = 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // source pixels
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PIX_W-1:0]      req_pixel_in,
   // remapped results
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [IDX_W-1:0]           rsp_dest_index,
   output logic [PIX_W-1:0]           rsp_pixel_out,
   output logic                       rsp_run_last,
   output logic                       rsp_frame_last,
   output logic [ODIM_W-1:0]          rsp_out_rows,
   output logic [ODIM_W-1:0]          rsp_out_cols,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type      cfg;
   logic         cfg_wr;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // mode, frame size and scale registers
   iatr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .cfg_wr    (cfg_wr)
   );

   // sequencer: idle -> scale -> mult -> emit (repeats per copy)
   iatr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, index arithmetic and result registers
   iatr_dp #(
      .MAX_DIM   (MAX_DIM),
      .MAX_SCALE (MAX_SCALE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cfg_wr         (cfg_wr),
      .cmd            (cmd),
      .sts            (sts),
      .req_pixel_in   (req_pixel_in),
      .rsp_dest_index (rsp_dest_index),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last),
      .rsp_out_rows   (rsp_out_rows),
      .rsp_out_cols   (rsp_out_cols)
   );

endmodule

`default_nettype wire

// File: sv/iatr_csr.sv
`default_nettype none

module iatr_csr
   import iatr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg,
   output logic                       cfg_wr
);

   cfg_type cfg_ff, cfg_in;
   logic    hit;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      case (csr_index)
         CSR_MODE: begin
            cfg_in.mode = csr_data[MODE_W-1:0];
            hit = 1'b1;
         end
         CSR_SRC_ROWS: begin
            cfg_in.src_rows = csr_data[DIM_FLD_W-1:0];
            hit = 1'b1;
         end
         CSR_SRC_COLS: begin
            cfg_in.src_cols = csr_data[DIM_FLD_W-1:0];
            hit = 1'b1;
         end
         CSR_SCALE: begin
            cfg_in.scale = csr_data[SCL_FLD_W-1:0];
            hit = 1'b1;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= MODE_ENLARGE;
         cfg_ff.src_rows <= DIM_FLD_W'(1);
         cfg_ff.src_cols <= DIM_FLD_W'(1);
         cfg_ff.scale    <= SCL_FLD_W'(1);
      end else if (csr_valid && hit) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg    = cfg_ff;
   assign cfg_wr = csr_valid & hit;

endmodule

`default_nettype wire

// File: sv/iatr_ctrl.sv
`default_nettype none

module iatr_ctrl
   import iatr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MULT;
         ST_MULT:  state_in = ST_EMIT;
         ST_EMIT:  if (!rsp_stall && sts.last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.scale = (state_ff == ST_SCALE);
      cmd.mult  = (state_ff == ST_MULT);
      cmd.step  = (state_ff == ST_EMIT) && !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/iatr_dp.sv
`default_nettype none

module iatr_dp
   import iatr_pkg::*;
#(
   parameter int MAX_DIM   = 4096,
   parameter int MAX_SCALE = 8
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             cfg_wr,
   input  wire ctrl_cmd_type     cmd,
   output ctrl_sts_type          sts,
   input  wire logic [PIX_W-1:0] req_pixel_in,
   output logic [IDX_W-1:0]      rsp_dest_index,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_run_last,
   output logic                  rsp_frame_last,
   output logic [ODIM_W-1:0]     rsp_out_rows,
   output logic [ODIM_W-1:0]     rsp_out_cols
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int SCL_W = $clog2(MAX_SCALE + 1);
   localparam int SD_W  = DIM_W + SCL_W;
   localparam int PR_W  = 2 * SD_W;

   // clamped configuration
   logic [DIM_W-1:0] rows, cols;
   logic [SCL_W-1:0] scl;

   always_comb begin
      if (cfg.src_rows == '0) rows = DIM_W'(1);
      else if (32'(cfg.src_rows) > 32'(MAX_DIM)) rows = DIM_W'(MAX_DIM);
      else rows = DIM_W'(cfg.src_rows);
      if (cfg.src_cols == '0) cols = DIM_W'(1);
      else if (32'(cfg.src_cols) > 32'(MAX_DIM)) cols = DIM_W'(MAX_DIM);
      else cols = DIM_W'(cfg.src_cols);
      if (cfg.scale == '0) scl = SCL_W'(1);
      else if (32'(cfg.scale) > 32'(MAX_SCALE)) scl = SCL_W'(MAX_SCALE);
      else scl = SCL_W'(cfg.scale);
   end

   // position counters
   logic [CNT_W-1:0] row_ff, row_in, col_ff, col_in;
   logic             col_end, row_end;

   assign col_end = (col_ff == CNT_W'(cols - DIM_W'(1)));
   assign row_end = (row_ff == CNT_W'(rows - DIM_W'(1)));

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + CNT_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.load) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // captured item
   logic [PIX_W-1:0] pix_ff;
   logic [CNT_W-1:0] r_ff, c_ff;
   logic             fend_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff  <= req_pixel_in;
         r_ff    <= row_ff;
         c_ff    <= col_ff;
         fend_ff <= row_end && col_end;
      end
   end

   // stage 1: small products and operand select, idx = a*b + d
   logic [SD_W-1:0]   rs, cs, rsd, csd;
   logic [SD_W-1:0]   a_in, b_in, d_in;
   logic [ODIM_W-1:0] orows_in, ocols_in;
   logic [SCL_W-1:0]  seff_in;
   logic [SD_W-1:0]   rx, cx, rowsx, colsx;

   assign rx    = SD_W'(r_ff);
   assign cx    = SD_W'(c_ff);
   assign rowsx = SD_W'(rows);
   assign colsx = SD_W'(cols);
   assign rs    = rx * SD_W'(scl);
   assign cs    = cx * SD_W'(scl);
   assign rsd   = rowsx * SD_W'(scl);
   assign csd   = colsx * SD_W'(scl);

   always_comb begin
      seff_in  = SCL_W'(1);
      orows_in = ODIM_W'(rows);
      ocols_in = ODIM_W'(cols);
      case (cfg.mode)
         MODE_ENLARGE: begin
            a_in     = rs;
            b_in     = csd;
            d_in     = cs;
            orows_in = ODIM_W'(rsd);
            ocols_in = ODIM_W'(csd);
            seff_in  = scl;
         end
         MODE_ROT_CW: begin
            a_in     = colsx - SD_W'(1) - cx;
            b_in     = rowsx;
            d_in     = rx;
            orows_in = ODIM_W'(cols);
            ocols_in = ODIM_W'(rows);
         end
         MODE_ROT_CCW: begin
            a_in     = cx;
            b_in     = rowsx;
            d_in     = rowsx - SD_W'(1) - rx;
            orows_in = ODIM_W'(cols);
            ocols_in = ODIM_W'(rows);
         end
         MODE_MIRROR: begin
            a_in = rx;
            b_in = colsx;
            d_in = colsx - SD_W'(1) - cx;
         end
         MODE_HALF: begin
            a_in = rowsx - SD_W'(1) - rx;
            b_in = colsx;
            d_in = colsx - SD_W'(1) - cx;
         end
         default: begin
            // unused codes: straight copy
            a_in = rx;
            b_in = colsx;
            d_in = cx;
         end
      endcase
   end

   logic [SD_W-1:0]   a_ff, b_ff, d_ff;
   logic [ODIM_W-1:0] orows_ff, ocols_ff;
   logic [SCL_W-1:0]  seff_ff;
   logic [IDX_W-1:0]  rstep_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         d_ff     <= d_in;
         orows_ff <= orows_in;
         ocols_ff <= ocols_in;
         seff_ff  <= seff_in;
         rstep_ff <= IDX_W'(csd);
      end
   end

   // stage 2: base index, then copies walk x inner, y outer
   logic [PR_W-1:0]  prod;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [SCL_W-1:0] x_ff, x_in, y_ff, y_in;
   logic             x_end, y_end;

   assign prod  = PR_W'(a_ff) * PR_W'(b_ff);
   assign x_end = (x_ff == seff_ff - SCL_W'(1));
   assign y_end = (y_ff == seff_ff - SCL_W'(1));

   always_comb begin
      base_in = base_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (cmd.mult) begin
         base_in = IDX_W'(prod) + IDX_W'(d_ff);
         x_in    = '0;
         y_in    = '0;
      end else if (cmd.step) begin
         if (x_end) begin
            x_in    = '0;
            y_in    = y_ff + SCL_W'(1);
            base_in = base_ff + rstep_ff;
         end else begin
            x_in = x_ff + SCL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign sts.last       = x_end && y_end;
   assign rsp_dest_index = base_ff + IDX_W'(x_ff);
   assign rsp_pixel_out  = pix_ff;
   assign rsp_run_last   = sts.last;
   assign rsp_frame_last = sts.last && fend_ff;
   assign rsp_out_rows   = orows_ff;
   assign rsp_out_cols   = ocols_ff;

endmodule

`default_nettype wire

// File: tb/tb_image_transform_address_remap_top.sv
`default_nettype none

module tb_image_transform_address_remap_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iatr_pkg::*;

   localparam int DIM_LIMIT     = 4096;
   localparam int SCALE_LIMIT   = 8;
   // idle cycles after the last result before each register write
   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES   = 24;
   localparam int RANDOM_PIXELS = 85;
   // hang bound: pixels x copies per pixel x longest stall runs, with margin
   localparam longint CYCLE_LIMIT = 1_500_000;

   // mode codes without a name in the package: all behave as a plain copy
   localparam logic [MODE_W-1:0] MODE_COPY5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_COPY6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_COPY7 = 3'd7;
   // register indexes past the last register: writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LAST  = 4'd15;

   // one output-frame write as the block should report it
   typedef struct packed {
      logic [IDX_W-1:0]  dest_index;
      logic [PIX_W-1:0]  pixel;
      logic              run_last;
      logic              frame_last;
      logic [ODIM_W-1:0] out_rows;
      logic [ODIM_W-1:0] out_cols;
   } dest_write_type;

   // ---------------------------------------------------------------------
   // Clock, stimulus-side signals (all known from time zero), DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;

   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [IDX_W-1:0]      rsp_dest_index;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_run_last;
   logic                  rsp_frame_last;
   logic [ODIM_W-1:0]     rsp_out_rows;
   logic [ODIM_W-1:0]     rsp_out_cols;

   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_data     = '0;

   always #4 clock = ~clock;

   image_transform_address_remap_top #(
      .MAX_DIM   (DIM_LIMIT),
      .MAX_SCALE (SCALE_LIMIT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dest_index (rsp_dest_index),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last),
      .rsp_out_rows   (rsp_out_rows),
      .rsp_out_cols   (rsp_out_cols),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow of the block: register copies, raster position, and the
   // frame writes still owed by the DUT (oldest first).
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0]    cur_mode  = MODE_ENLARGE;
   logic [DIM_FLD_W-1:0] cur_rows  = DIM_FLD_W'(1);
   logic [DIM_FLD_W-1:0] cur_cols  = DIM_FLD_W'(1);
   logic [SCL_FLD_W-1:0] cur_scale = SCL_FLD_W'(1);
   longint unsigned      row_at    = 0;
   longint unsigned      col_at    = 0;
   dest_write_type       dest_writes[$];

   int     errors      = 0;
   longint cycle_count = 0;
   bit     req_calm    = 1'b0;   // no sender gaps while set
   bit     rsp_calm    = 1'b0;   // no receiver stalls while set

   task automatic flag(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
   endtask

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned gap_cycles(input bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // out-of-range sizes: zero counts as one, oversize counts as the max
   function automatic longint unsigned clamp_to(input longint unsigned v,
                                                input longint unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Raster position -> output-frame index for the current mode, then step
   // the raster (wraps to the top after the last pixel of the frame).
   task automatic map_pixel_to_dest(input logic [PIX_W-1:0] pix);
      longint unsigned nr, nc, r, c, s, idx, orow, ocol;
      bit              at_end;
      dest_write_type  w;
      nr     = clamp_to(longint'(cur_rows), DIM_LIMIT);
      nc     = clamp_to(longint'(cur_cols), DIM_LIMIT);
      r      = row_at;
      c      = col_at;
      at_end = (r == nr - 1) && (c == nc - 1);
      w.pixel = pix;
      if (cur_mode == MODE_ENLARGE) begin
         // s x s block, row of the block outer, column inner
         s = clamp_to(longint'(cur_scale), SCALE_LIMIT);
         for (longint unsigned y = 0; y < s; y++) begin
            for (longint unsigned x = 0; x < s; x++) begin
               w.dest_index = IDX_W'((r * s + y) * (nc * s) + c * s + x);
               w.run_last   = (y == s - 1) && (x == s - 1);
               w.frame_last = w.run_last && at_end;
               w.out_rows   = ODIM_W'(nr * s);
               w.out_cols   = ODIM_W'(nc * s);
               dest_writes.push_back(w);
            end
         end
      end else begin
         case (cur_mode)
            MODE_ROT_CW: begin
               idx = (nc - 1 - c) * nr + r;
               orow = nc; ocol = nr;
            end
            MODE_ROT_CCW: begin
               idx = c * nr + (nr - 1 - r);
               orow = nc; ocol = nr;
            end
            MODE_MIRROR: begin
               idx = r * nc + (nc - 1 - c);
               orow = nr; ocol = nc;
            end
            MODE_HALF: begin
               idx = (nr - 1 - r) * nc + (nc - 1 - c);
               orow = nr; ocol = nc;
            end
            default: begin
               idx = r * nc + c;
               orow = nr; ocol = nc;
            end
         endcase
         w.dest_index = IDX_W'(idx);
         w.run_last   = 1'b1;
         w.frame_last = at_end;
         w.out_rows   = ODIM_W'(orow);
         w.out_cols   = ODIM_W'(ocol);
         dest_writes.push_back(w);
      end
      c++;
      if (c >= nc) begin
         c = 0;
         r++;
         if (r >= nr) r = 0;
      end
      row_at = r;
      col_at = c;
   endtask

   // register write into the shadow; any mapped write restarts the frame
   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      bit hit;
      hit = 1'b1;
      case (idx)
         CSR_MODE:     cur_mode  = data[MODE_W-1:0];
         CSR_SRC_ROWS: cur_rows  = data[DIM_FLD_W-1:0];
         CSR_SRC_COLS: cur_cols  = data[DIM_FLD_W-1:0];
         CSR_SCALE:    cur_scale = data[SCL_FLD_W-1:0];
         default:      hit = 1'b0;
      endcase
      if (hit) begin
         row_at = 0;
         col_at = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Channel drivers. Everything changes on the falling edge; transfers are
   // judged on the rising edge from pre-edge values.
   // ---------------------------------------------------------------------

   // Stop offering pixels and wait until every owed write has come out.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (dest_writes.size() != 0) @(posedge clock);
   endtask

   // One pixel transfer. Valid stays high on return so the next call can go
   // back-to-back; anything else lowers it on the next falling edge first.
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int unsigned g;
      @(negedge clock);
      g = gap_cycles(req_calm);
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      map_pixel_to_dest(pix);
   endtask

   // Register writes only with the block idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic mode_burst(input logic [MODE_W-1:0] m, input int unsigned n);
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      repeat (n) send_pixel(PIX_W'($urandom));
   endtask

   // Receiver: random stall runs, one assignment per falling edge.
   int unsigned stall_left = 0;
   always @(negedge clock) begin : drive_rsp_stall
      int unsigned g;
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         g = gap_cycles(rsp_calm);
         if (g == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = g - 1;
         end
      end
   end

   // Each result transfer against the oldest owed write, field by field.
   always @(posedge clock) begin : check_dest_writes
      dest_write_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dest_writes.size() == 0) begin
            flag($sformatf("result with none owed: index %0d", rsp_dest_index));
         end else begin
            w = dest_writes.pop_front();
            if (rsp_dest_index !== w.dest_index)
               flag($sformatf("dest_index %0d, want %0d", rsp_dest_index, w.dest_index));
            if (rsp_pixel_out !== w.pixel)
               flag($sformatf("pixel_out %h, want %h", rsp_pixel_out, w.pixel));
            if (rsp_run_last !== w.run_last)
               flag($sformatf("run_last %b, want %b (index %0d)",
                              rsp_run_last, w.run_last, w.dest_index));
            if (rsp_frame_last !== w.frame_last)
               flag($sformatf("frame_last %b, want %b (index %0d)",
                              rsp_frame_last, w.frame_last, w.dest_index));
            if (rsp_out_rows !== w.out_rows)
               flag($sformatf("out_rows %0d, want %0d", rsp_out_rows, w.out_rows));
            if (rsp_out_cols !== w.out_cols)
               flag($sformatf("out_cols %0d, want %0d", rsp_out_cols, w.out_cols));
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset state: enlarge x1 on a 1x1 frame, every pixel ends a frame.
   task automatic test_reset_state();
      send_pixel('0);
      send_pixel('1);
   endtask

   // Every mode code: the four remapping modes on a 2x3 frame at the first two
   // raster positions, spare codes at the first one as a straight copy.
   task automatic test_mode_mapping();
      write_reg(CSR_SRC_ROWS, 2);
      write_reg(CSR_SRC_COLS, 3);
      mode_burst(MODE_ROT_CW, 2);
      mode_burst(MODE_ROT_CCW, 2);
      mode_burst(MODE_MIRROR, 2);
      mode_burst(MODE_HALF, 2);
      mode_burst(MODE_COPY5, 1);
      mode_burst(MODE_COPY6, 1);
      mode_burst(MODE_COPY7, 1);
      // 2x enlarge of a 1x2 strip: whole frame, last-of-frame on final copy
      write_reg(CSR_SRC_ROWS, 1);
      write_reg(CSR_SRC_COLS, 2);
      write_reg(CSR_SCALE, 2);
      mode_burst(MODE_ENLARGE, 2);
   endtask

   // Size and scale limits, including out-of-range register values.
   task automatic test_range_clamps();
      // zero rows -> 1, all-ones cols -> max width, scale above max -> max
      write_reg(CSR_SRC_ROWS, '0);
      write_reg(CSR_SRC_COLS, '1);
      write_reg(CSR_SCALE, '1);
      mode_burst(MODE_ENLARGE, 1);
      // full frame: half turn puts the first pixel at the largest index
      write_reg(CSR_SRC_ROWS, CSR_DATA_W'(DIM_LIMIT));
      write_reg(CSR_SRC_COLS, CSR_DATA_W'(DIM_LIMIT));
      mode_burst(MODE_HALF, 1);
      // biggest output frame the block can report
      write_reg(CSR_SCALE, CSR_DATA_W'(SCALE_LIMIT));
      mode_burst(MODE_ENLARGE, 1);
      // zero scale acts as 1; all-ones rows clamp to max
      write_reg(CSR_SCALE, '0);
      write_reg(CSR_SRC_ROWS, '1);
      mode_burst(MODE_ENLARGE, 1);
   endtask

   // Mapped writes restart the raster, unmapped indexes leave it alone.
   task automatic test_register_restart();
      write_reg(CSR_SRC_ROWS, 2);
      write_reg(CSR_SRC_COLS, 2);
      mode_burst(MODE_MIRROR, 1);
      write_reg(CSR_UNMAPPED_FIRST, CSR_DATA_W'($urandom));
      write_reg(CSR_UNMAPPED_LAST, CSR_DATA_W'($urandom));
      send_pixel(PIX_W'($urandom));          // still mid-row
      write_reg(CSR_SCALE, 1);               // unused in mirror, still restarts
      send_pixel(PIX_W'($urandom));          // back at the top-left
   endtask

   // Past the last pixel the raster wraps and a new frame starts.
   task automatic test_frame_wrap();
      write_reg(CSR_SRC_ROWS, 1);
      write_reg(CSR_SRC_COLS, 2);
      mode_burst(MODE_ROT_CW, 3);
   endtask

   function automatic logic [DIM_FLD_W-1:0] pick_dim();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return DIM_FLD_W'($urandom_range(1, 5));
      if (r < 95) return DIM_FLD_W'($urandom);
      return $urandom_range(0, 1) ? DIM_FLD_W'(DIM_LIMIT) : '1;
   endfunction

   // Random settings, mostly whole small frames (plus a little wrap), some
   // cut short by the next setting, some on huge frames.
   task automatic test_random_frames(input int unsigned target);
      int unsigned          sent, burst;
      longint unsigned      frame_px;
      logic [MODE_W-1:0]    m;
      logic [DIM_FLD_W-1:0] rows, cols;
      logic [SCL_FLD_W-1:0] s;
      logic [CSR_DATA_W-1:0] junk;
      sent = 0;
      while (sent < target) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         m    = MODE_W'($urandom_range(MODE_ENLARGE, MODE_COPY7));
         rows = pick_dim();
         cols = pick_dim();
         s    = ($urandom_range(0, 9) < 7) ? SCL_FLD_W'($urandom_range(1, 3))
                                           : SCL_FLD_W'($urandom);
         // upper data bits are don't-care for the narrow registers
         junk = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_IDX_W'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)),
                      CSR_DATA_W'($urandom));
         write_reg(CSR_SRC_ROWS, rows);
         write_reg(CSR_SRC_COLS, cols);
         write_reg(CSR_SCALE, {junk[CSR_DATA_W-1:SCL_FLD_W], s});
         write_reg(CSR_MODE, {junk[CSR_DATA_W-1:MODE_W], m});
         frame_px = clamp_to(longint'(rows), DIM_LIMIT) *
                    clamp_to(longint'(cols), DIM_LIMIT);
         if (frame_px <= 20)
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'(frame_px))
                                                : 32'(frame_px) + $urandom_range(0, 3);
         else
            burst = $urandom_range(1, 6);
         if (burst > target - sent) burst = target - sent;
         for (int unsigned k = 0; k < burst; k++) begin
            // sender holds off until the block has delivered everything
            if ($urandom_range(0, 11) == 0 || sent == target / 2) drain_results();
            send_pixel(PIX_W'($urandom));
            sent++;
         end
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence: synchronous reset, directed tests, random frames,
   // drain, settle, verdict.
   // ---------------------------------------------------------------------
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_mode_mapping();
      test_range_clamps();
      test_register_restart();
      test_frame_wrap();
      test_random_frames(RANDOM_PIXELS);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);   // catch any stray transfer
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
